// ===== sv/frba_pkg.sv =====
package frba_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_BITS     = 32;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_BITS    = 2 * ADDR_BITS;

    localparam logic [ADDR_BITS-1:0] ADDR_MASK = {ADDR_BITS{1'b1}};

    // Result status codes.
    localparam logic [2:0] ST_FROM_FREE  = 3'd0;
    localparam logic [2:0] ST_GROWN      = 3'd1;
    localparam logic [2:0] ST_NO_MEMORY  = 3'd2;
    localparam logic [2:0] ST_FREED      = 3'd3;
    localparam logic [2:0] ST_NULL       = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;

    // Item kinds.
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_FIT_POLICY   = 2'd0;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [1:0] REG_HEAP_LIMIT   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CMP,
        S_A_DONE,
        S_R_RD,
        S_R_CMP,
        S_R_DONE,
        S_SH_CHK,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } state_t;

endpackage

// ===== sv/frba_ram.sv =====
module frba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/first_best_fit_region_allocator_core.sv =====
// An allocate scans the table entry by entry (read, then compare) and, when a region is used
// up, moves every entry behind it down one place (check, read, write); a release scans the same
// way and moves entries on insert or merge. Worst case is a best-fit allocate over a full table
// that uses up the first region.
// Throughput: one beat at a time; the next input is taken once the result is registered.
// Reset (aresetn, synchronous, active low) empties the table, zeroes heap top and free total,
// and restores fit_policy 0, header_bytes 32 and heap_limit all ones. No clearing pass.
module first_best_fit_region_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_request_bytes,
    input  logic [31:0] s_payload_address,
    input  logic [31:0] s_block_bytes,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_granted_address,
    output logic [31:0] m_granted_block_bytes,
    output logic [31:0] m_free_total,
    output logic [31:0] m_heap_size
);

    localparam int AB = frba_pkg::ADDR_BITS;
    localparam int CB = frba_pkg::CNT_BITS;
    localparam int IB = frba_pkg::IDX_BITS;

    // Configuration registers.
    logic          fit_policy_reg;
    logic [7:0]    header_reg;
    logic [AB-1:0] limit_reg;

    // Sequencer and table bookkeeping.
    frba_pkg::state_t state_reg, state_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [CB-1:0] idx_reg, idx_next;
    logic [CB-1:0] k_reg, k_next;
    logic [CB-1:0] pick_reg, pick_next;
    logic          found_reg, found_next;
    logic          has_next_reg, has_next_next;
    logic          up_reg, up_next;

    // Item operands and the entries remembered during a scan.
    logic [AB:0]   t_reg, t_next;
    logic [AB-1:0] s_reg, s_next;
    logic [AB-1:0] b_reg, b_next;
    logic [AB-1:0] pick_start_reg, pick_start_next;
    logic [AB-1:0] pick_len_reg, pick_len_next;
    logic [AB-1:0] prev_start_reg, prev_start_next;
    logic [AB-1:0] prev_len_reg, prev_len_next;
    logic [AB-1:0] next_start_reg, next_start_next;
    logic [AB-1:0] next_len_reg, next_len_next;

    // Allocator state and the pending result.
    logic [AB-1:0] heap_top_reg, heap_top_next;
    logic [AB-1:0] free_reg, free_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [AB-1:0] res_addr_reg, res_addr_next;
    logic [AB-1:0] res_blk_reg, res_blk_next;

    // Output register.
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [AB-1:0] m_addr_reg, m_addr_next;
    logic [AB-1:0] m_blk_reg, m_blk_next;
    logic [AB-1:0] m_free_reg, m_free_next;
    logic [AB-1:0] m_heap_reg, m_heap_next;

    // Table RAM: each word is {start, length}.
    logic                            ram_we;
    logic [IB-1:0]                   ram_waddr;
    logic [frba_pkg::ENTRY_BITS-1:0] ram_wdata;
    logic [IB-1:0]                   ram_raddr;
    logic [frba_pkg::ENTRY_BITS-1:0] ram_rdata;
    logic [AB-1:0]                   rd_start;
    logic [AB-1:0]                   rd_len;

    // Helper values for the decision states.
    logic [AB-1:0] left_len;
    logic [AB+1:0] grow_sum;
    logic [AB-1:0] prev_end;
    logic [AB-1:0] blk_end;
    logic [AB-1:0] joined_len;
    logic          join_prev;
    logic          join_next;
    logic          join_both;
    logic          out_free;

    frba_ram #(
        .WIDTH(frba_pkg::ENTRY_BITS),
        .DEPTH(frba_pkg::TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[2*AB-1:AB];
    assign rd_len   = ram_rdata[AB-1:0];

    assign left_len   = pick_len_reg - t_reg[AB-1:0];
    assign grow_sum   = {2'b00, heap_top_reg} + {1'b0, t_reg};
    assign prev_end   = prev_start_reg + prev_len_reg;
    assign blk_end    = s_reg + b_reg;
    assign joined_len = prev_len_reg + b_reg;
    assign join_prev  = (idx_reg != '0) && (prev_end == s_reg);
    assign join_next  = has_next_reg && (next_start_reg == blk_end);
    // After growing the previous region, check whether it now touches the next one.
    assign join_both  = has_next_reg && ((prev_start_reg + joined_len) == next_start_reg);
    assign out_free   = !m_valid_reg || m_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == frba_pkg::S_IDLE);

    assign m_valid               = m_valid_reg;
    assign m_status              = m_status_reg;
    assign m_granted_address     = m_addr_reg;
    assign m_granted_block_bytes = m_blk_reg;
    assign m_free_total          = m_free_reg;
    assign m_heap_size           = m_heap_reg;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= 1'b0;
            header_reg     <= 8'd32;
            limit_reg      <= frba_pkg::ADDR_MASK;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                frba_pkg::REG_FIT_POLICY:   fit_policy_reg <= cfg_data[0];
                frba_pkg::REG_HEADER_BYTES: header_reg     <= cfg_data[7:0];
                frba_pkg::REG_HEAP_LIMIT:   limit_reg      <= cfg_data[AB-1:0];
                default: ;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            frba_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_kind == frba_pkg::KIND_ALLOC) begin
                        state_next = frba_pkg::S_A_RD;
                    end else if (s_payload_address == '0) begin
                        state_next = frba_pkg::S_FINISH;
                    end else begin
                        state_next = frba_pkg::S_R_RD;
                    end
                end
            end
            frba_pkg::S_A_RD: begin
                state_next = (idx_reg < cnt_reg) ? frba_pkg::S_A_CMP : frba_pkg::S_A_DONE;
            end
            frba_pkg::S_A_CMP: begin
                if (({1'b0, rd_len} >= t_reg) && !fit_policy_reg) begin
                    state_next = frba_pkg::S_A_DONE;
                end else begin
                    state_next = frba_pkg::S_A_RD;
                end
            end
            frba_pkg::S_A_DONE: begin
                if (found_reg && ({1'b0, left_len} <= {{(AB-8){1'b0}}, 1'b0, header_reg})) begin
                    state_next = frba_pkg::S_SH_CHK;
                end else begin
                    state_next = frba_pkg::S_FINISH;
                end
            end
            frba_pkg::S_R_RD: begin
                state_next = (idx_reg < cnt_reg) ? frba_pkg::S_R_CMP : frba_pkg::S_R_DONE;
            end
            frba_pkg::S_R_CMP: begin
                state_next = (rd_start <= s_reg) ? frba_pkg::S_R_RD : frba_pkg::S_R_DONE;
            end
            frba_pkg::S_R_DONE: begin
                if (join_prev) begin
                    state_next = join_both ? frba_pkg::S_SH_CHK : frba_pkg::S_FINISH;
                end else if (join_next) begin
                    state_next = frba_pkg::S_FINISH;
                end else if (cnt_reg >= CB'(frba_pkg::TABLE_ENTRIES)) begin
                    state_next = frba_pkg::S_FINISH;
                end else begin
                    state_next = frba_pkg::S_SH_CHK;
                end
            end
            frba_pkg::S_SH_CHK: begin
                if (up_reg) begin
                    state_next = (k_reg > idx_reg) ? frba_pkg::S_SH_RD : frba_pkg::S_FINISH;
                end else begin
                    state_next = ((k_reg + 1'b1) < cnt_reg) ? frba_pkg::S_SH_RD
                                                            : frba_pkg::S_FINISH;
                end
            end
            frba_pkg::S_SH_RD: state_next = frba_pkg::S_SH_WR;
            frba_pkg::S_SH_WR: state_next = frba_pkg::S_SH_CHK;
            frba_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = frba_pkg::S_IDLE;
                end
            end
            default: state_next = frba_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result logic.
    always_comb begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        has_next_next   = has_next_reg;
        up_next         = up_reg;
        t_next          = t_reg;
        s_next          = s_reg;
        b_next          = b_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        next_start_next = next_start_reg;
        next_len_next   = next_len_reg;
        heap_top_next   = heap_top_reg;
        free_next       = free_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_blk_next    = res_blk_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_blk_next      = m_blk_reg;
        m_free_next     = m_free_reg;
        m_heap_next     = m_heap_reg;
        ram_we          = 1'b0;
        ram_waddr       = k_reg[IB-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[IB-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            frba_pkg::S_IDLE: begin
                idx_next        = '0;
                found_next      = 1'b0;
                has_next_next   = 1'b0;
                t_next          = {1'b0, s_request_bytes} + {{(AB-7){1'b0}}, header_reg};
                s_next          = s_payload_address - {{(AB-8){1'b0}}, header_reg};
                b_next          = s_block_bytes;
                res_status_next = frba_pkg::ST_NULL;
                res_addr_next   = '0;
                res_blk_next    = '0;
            end
            frba_pkg::S_A_CMP: begin
                if ({1'b0, rd_len} >= t_reg) begin
                    if (!found_reg || (rd_len < pick_len_reg)) begin
                        pick_next       = idx_reg;
                        pick_start_next = rd_start;
                        pick_len_next   = rd_len;
                    end
                    found_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            frba_pkg::S_A_DONE: begin
                if (found_reg) begin
                    res_status_next = frba_pkg::ST_FROM_FREE;
                    res_addr_next   = pick_start_reg + {{(AB-8){1'b0}}, header_reg};
                    if ({1'b0, left_len} <= {{(AB-8){1'b0}}, 1'b0, header_reg}) begin
                        // Leftover too small to keep: grant the whole region.
                        res_blk_next = pick_len_reg;
                        free_next    = free_reg - pick_len_reg;
                        k_next       = pick_reg;
                        up_next      = 1'b0;
                    end else begin
                        res_blk_next = t_reg[AB-1:0];
                        free_next    = free_reg - t_reg[AB-1:0];
                        ram_we       = 1'b1;
                        ram_waddr    = pick_reg[IB-1:0];
                        ram_wdata    = {pick_start_reg + t_reg[AB-1:0], left_len};
                    end
                end else if ((grow_sum > {2'b00, frba_pkg::ADDR_MASK}) ||
                             (grow_sum > {2'b00, limit_reg})) begin
                    res_status_next = frba_pkg::ST_NO_MEMORY;
                end else begin
                    res_status_next = frba_pkg::ST_GROWN;
                    res_addr_next   = heap_top_reg + {{(AB-8){1'b0}}, header_reg};
                    res_blk_next    = t_reg[AB-1:0];
                    heap_top_next   = grow_sum[AB-1:0];
                end
            end
            frba_pkg::S_R_CMP: begin
                if (rd_start <= s_reg) begin
                    prev_start_next = rd_start;
                    prev_len_next   = rd_len;
                    idx_next        = idx_reg + 1'b1;
                end else begin
                    next_start_next = rd_start;
                    next_len_next   = rd_len;
                    has_next_next   = 1'b1;
                end
            end
            frba_pkg::S_R_DONE: begin
                res_status_next = frba_pkg::ST_FREED;
                free_next       = free_reg + b_reg;
                if (join_prev) begin
                    ram_we    = 1'b1;
                    ram_waddr = IB'(idx_reg - 1'b1);
                    ram_wdata = {prev_start_reg,
                                 join_both ? joined_len + next_len_reg : joined_len};
                    k_next    = idx_reg;
                    up_next   = 1'b0;
                end else if (join_next) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[IB-1:0];
                    ram_wdata = {s_reg, next_len_reg + b_reg};
                end else if (cnt_reg >= CB'(frba_pkg::TABLE_ENTRIES)) begin
                    res_status_next = frba_pkg::ST_TABLE_FULL;
                    free_next       = free_reg;
                end else begin
                    k_next  = cnt_reg;
                    up_next = 1'b1;
                end
            end
            frba_pkg::S_SH_CHK: begin
                if (up_reg) begin
                    if (k_reg <= idx_reg) begin
                        // Gap is open: drop the released block into it.
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg[IB-1:0];
                        ram_wdata = {s_reg, b_reg};
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end else if ((k_reg + 1'b1) >= cnt_reg) begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            frba_pkg::S_SH_RD: begin
                ram_raddr = up_reg ? IB'(k_reg - 1'b1) : IB'(k_reg + 1'b1);
            end
            frba_pkg::S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[IB-1:0];
                ram_wdata = ram_rdata;
                k_next    = up_reg ? k_reg - 1'b1 : k_reg + 1'b1;
            end
            frba_pkg::S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_blk_next    = res_blk_reg;
                    m_free_next   = free_reg;
                    m_heap_next   = heap_top_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= frba_pkg::S_IDLE;
            cnt_reg      <= '0;
            heap_top_reg <= '0;
            free_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            heap_top_reg <= heap_top_next;
            free_reg     <= free_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        k_reg           <= k_next;
        pick_reg        <= pick_next;
        found_reg       <= found_next;
        has_next_reg    <= has_next_next;
        up_reg          <= up_next;
        t_reg           <= t_next;
        s_reg           <= s_next;
        b_reg           <= b_next;
        pick_start_reg  <= pick_start_next;
        pick_len_reg    <= pick_len_next;
        prev_start_reg  <= prev_start_next;
        prev_len_reg    <= prev_len_next;
        next_start_reg  <= next_start_next;
        next_len_reg    <= next_len_next;
        res_status_reg  <= res_status_next;
        res_addr_reg    <= res_addr_next;
        res_blk_reg     <= res_blk_next;
        m_status_reg    <= m_status_next;
        m_addr_reg      <= m_addr_next;
        m_blk_reg       <= m_blk_next;
        m_free_reg      <= m_free_next;
        m_heap_reg      <= m_heap_next;
    end

endmodule

// ===== sv/frba_checker.sv =====
module frba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_granted_address
);

    // A beat keeps the block busy for at least the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= frba_pkg::ST_TABLE_FULL))
        else $error("status code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != frba_pkg::ST_FROM_FREE) && (m_status != frba_pkg::ST_GROWN)
        |-> (m_granted_address == '0))
        else $error("address reported without a grant");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped while stalled");

endmodule

bind first_best_fit_region_allocator_core frba_checker u_frba_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_granted_address (m_granted_address)
);

// ===== tb/heap_checker.sv =====
`timescale 1ns / 100ps

module heap_checker
    import frba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_request_bytes,
    input  logic [31:0] s_payload_address,
    input  logic [31:0] s_block_bytes,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_granted_address,
    input  logic [31:0] m_granted_block_bytes,
    input  logic [31:0] m_free_total,
    input  logic [31:0] m_heap_size,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          full_count,
    output int          grown_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [31:0] blk;
        logic [31:0] free_total;
        logic [31:0] heap;
    } heap_result_t;

    logic [31:0] free_start [TABLE_ENTRIES];
    logic [31:0] free_len [TABLE_ENTRIES];
    int          n_regions;
    logic [31:0] top_bytes;
    logic [31:0] free_sum;
    logic        best_fit;
    logic [7:0]  hdr;
    logic [31:0] limit_bytes;

    heap_result_t expected_results[$];

    function automatic void remove_region(int pos);
        for (int k = pos; k + 1 < n_regions; k++) begin
            free_start[k] = free_start[k+1];
            free_len[k] = free_len[k+1];
        end
        n_regions--;
    endfunction

    function automatic heap_result_t allocate_block(logic [31:0] req);
        heap_result_t r;
        logic [32:0] need;
        logic [33:0] grow;
        int pick;
        logic [31:0] st;
        logic [32:0] left;
        r = '0;
        need = {1'b0, req} + hdr;
        pick = -1;
        for (int i = 0; i < n_regions; i++) begin
            if ({1'b0, free_len[i]} >= need) begin
                if (pick < 0) begin
                    pick = i;
                    if (!best_fit) break;
                end else if (free_len[i] < free_len[pick]) begin
                    pick = i;
                end
            end
        end
        if (pick >= 0) begin
            st = free_start[pick];
            left = {1'b0, free_len[pick]} - need;
            if (left <= hdr) begin
                r.blk = free_len[pick];
                free_sum = free_sum - free_len[pick];
                remove_region(pick);
            end else begin
                r.blk = need[31:0];
                free_start[pick] = st + need[31:0];
                free_len[pick] = left[31:0];
                free_sum = free_sum - need[31:0];
            end
            r.addr = st + hdr;
            r.status = ST_FROM_FREE;
        end else begin
            grow = {2'b0, top_bytes} + need;
            if (need[32] || grow > 34'hFFFF_FFFF || grow > {2'b0, limit_bytes}) begin
                r.status = ST_NO_MEMORY;
            end else begin
                r.addr = top_bytes + hdr;
                r.blk = need[31:0];
                top_bytes = grow[31:0];
                r.status = ST_GROWN;
            end
        end
        return r;
    endfunction

    function automatic heap_result_t release_block(logic [31:0] pa, logic [31:0] b);
        heap_result_t r;
        logic [31:0] s, e;
        int pos;
        logic join_lo, join_hi;
        r = '0;
        if (pa == 0) begin
            r.status = ST_NULL;
            return r;
        end
        s = pa - hdr;
        e = s + b;
        pos = 0;
        while (pos < n_regions && free_start[pos] <= s) pos++;
        join_lo = pos > 0 && (free_start[pos-1] + free_len[pos-1]) == s;
        join_hi = pos < n_regions && free_start[pos] == e;
        if (join_lo) begin
            free_len[pos-1] = free_len[pos-1] + b;
            if (pos < n_regions && (free_start[pos-1] + free_len[pos-1]) == free_start[pos]) begin
                free_len[pos-1] = free_len[pos-1] + free_len[pos];
                remove_region(pos);
            end
        end else if (join_hi) begin
            free_start[pos] = s;
            free_len[pos] = free_len[pos] + b;
        end else begin
            if (n_regions >= TABLE_ENTRIES) begin
                r.status = ST_TABLE_FULL;
                return r;
            end
            for (int k = n_regions; k > pos; k--) begin
                free_start[k] = free_start[k-1];
                free_len[k] = free_len[k-1];
            end
            free_start[pos] = s;
            free_len[pos] = b;
            n_regions++;
        end
        free_sum = free_sum + b;
        r.status = ST_FREED;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h", result_count, what, got,
                 want);
        fail_count++;
    endtask

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        heap_result_t r, w;
        if (!aresetn) begin
            n_regions <= 0;
            top_bytes <= '0;
            free_sum <= '0;
            best_fit <= 1'b0;
            hdr <= 8'd32;
            limit_bytes <= 32'hFFFF_FFFF;
            expected_results.delete();
            fail_count <= 0;
            result_count <= 0;
            full_count <= 0;
            grown_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FIT_POLICY: best_fit = cfg_data[0];
                    REG_HEADER_BYTES: hdr = cfg_data[7:0];
                    REG_HEAP_LIMIT: limit_bytes = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_kind == KIND_ALLOC) r = allocate_block(s_request_bytes);
                else r = release_block(s_payload_address, s_block_bytes);
                r.free_total = free_sum;
                r.heap = top_bytes;
                if (r.status == ST_TABLE_FULL) full_count++;
                if (r.status == ST_GROWN) grown_count++;
                expected_results.push_back(r);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result beat with status %0d", m_status);
                    fail_count++;
                end else begin
                    w = expected_results.pop_front();
                    if (m_status != w.status) report_mismatch("status", m_status, w.status);
                    if (m_granted_address != w.addr)
                        report_mismatch("granted_address", m_granted_address, w.addr);
                    if (m_granted_block_bytes != w.blk)
                        report_mismatch("granted_block_bytes", m_granted_block_bytes, w.blk);
                    if (m_free_total != w.free_total)
                        report_mismatch("free_total", m_free_total, w.free_total);
                    if (m_heap_size != w.heap) report_mismatch("heap_size", m_heap_size, w.heap);
                end
                result_count++;
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the region allocator. The checker beside the DUT
// keeps its own copy of the free-region table and predicts every result beat.
module testbench;
    import frba_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_ALLOC;
    logic [31:0] s_request_bytes = '0;
    logic [31:0] s_payload_address = '0;
    logic [31:0] s_block_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_granted_address, m_granted_block_bytes, m_free_total, m_heap_size;

    int fail_count, pending_count, result_count, full_count, grown_count;
    int items_sent = 0;
    int idle_cycles = 0;
    bit stimulus_done = 0;
    bit long_stall = 0;

    // Blocks granted so far and still held; releases draw from this list so
    // that most of them coalesce with real neighbors.
    logic [31:0] held_addr[$];
    logic [31:0] held_size[$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    first_best_fit_region_allocator_core DUT (.*);

    heap_checker checker_i (.*);

    // Grants are harvested here so that later releases can return them.
    always @(posedge aclk) begin
        if (m_valid && m_ready &&
            (m_status == ST_FROM_FREE || m_status == ST_GROWN)) begin
            held_addr.push_back(m_granted_address);
            held_size.push_back(m_granted_block_bytes);
        end
    end

    // The watchdog counts cycles without any accepted beat. Its limit is far
    // above what the slowest item needs, so no correct run comes near it.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure with stretches of none, plus one long
    // hold-off requested by the stimulus so the DUT fills and stalls its input.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall) begin
                m_ready <= 1'b0;
                for (int k = 0; k < 400; k++) @(negedge aclk);
                long_stall = 0;
            end
            gap = (result_count / 200) % 2 ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one item, waiting a random gap first unless told not to.
    task automatic send_item(logic kind, logic [31:0] req, logic [31:0] pa, logic [31:0] b,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_request_bytes <= req;
        s_payload_address <= pa;
        s_block_bytes <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // Returns a held block, or sometimes a nonsense one.
    task automatic release_random(bit no_gap);
        int k;
        if (held_addr.size() == 0 || $urandom_range(0, 9) == 0) begin
            send_item(KIND_RELEASE, $urandom, $urandom, $urandom_range(0, 500), no_gap);
        end else begin
            k = $urandom_range(0, held_addr.size() - 1);
            send_item(KIND_RELEASE, $urandom, held_addr[k], held_size[k], no_gap);
            held_addr.delete(k);
            held_size.delete(k);
        end
    endtask

    task automatic random_phase(int count, int max_req);
        bit burst;
        for (int n = 0; n < count; n++) begin
            burst = (n / 60) % 3 == 2;
            case ($urandom_range(0, 19))
                0: send_item(KIND_ALLOC, $urandom, $urandom, $urandom, burst);
                1, 2, 3, 4, 5, 6, 7, 8, 9:
                    send_item(KIND_ALLOC, $urandom_range(0, max_req), $urandom, $urandom,
                              burst);
                default: release_random(burst);
            endcase
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: growth, splits, exact fits, coalescing both ways, null
        // release, zero sizes, a bogus release, and the growth limit.
        send_item(KIND_ALLOC, 32'd0, 0, 0, 0);
        send_item(KIND_ALLOC, 32'd100, 0, 0, 0);
        send_item(KIND_ALLOC, 32'd200, 0, 0, 0);
        send_item(KIND_ALLOC, 32'd50, 0, 0, 0);
        send_item(KIND_RELEASE, 0, 32'd0, 32'd77, 0);
        send_item(KIND_RELEASE, 0, 32'd64, 32'd132, 0);
        send_item(KIND_RELEASE, 0, 32'd228, 32'd82, 0);
        send_item(KIND_RELEASE, 0, 32'd196, 32'd232, 0);
        send_item(KIND_ALLOC, 32'd10, 0, 0, 0);
        send_item(KIND_ALLOC, 32'd400, 0, 0, 0);
        send_item(KIND_RELEASE, 0, 32'd5, 32'd0, 0);
        send_item(KIND_RELEASE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(KIND_ALLOC, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(KIND_ALLOC, 32'hFFFF_FFDF, 0, 0, 0);
        drain_results();

        // Best fit, tiny header, tight limit: growth fails often.
        write_register(REG_FIT_POLICY, 32'd1);
        write_register(REG_HEADER_BYTES, 32'd1);
        write_register(REG_HEAP_LIMIT, 32'd6000);
        send_item(KIND_ALLOC, 32'd5999, 0, 0, 0);
        send_item(KIND_ALLOC, 32'd6000, 0, 0, 0);
        random_phase(350, 300);

        // The long hold-off: results stop while items keep coming.
        long_stall = 1;
        write_register(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        write_register(REG_HEADER_BYTES, 32'd255);
        write_register(REG_FIT_POLICY, 32'd0);
        random_phase(350, 2000);

        // Many small releases of disjoint blocks fill the table.
        write_register(REG_HEADER_BYTES, 32'd16);
        write_register(REG_FIT_POLICY, 32'd1);
        write_register(REG_HEAP_LIMIT, 32'd0);
        for (int n = 0; n < 80; n++)
            send_item(KIND_RELEASE, 0, 32'h1000_0000 + n * 64, 32'd8, n % 2);
        random_phase(300, 200);

        write_register(REG_FIT_POLICY, 32'd0);
        write_register(REG_HEADER_BYTES, 32'd32);
        write_register(REG_HEAP_LIMIT, 32'h00FF_FFFF);
        random_phase(300, 5000);

        $display("sent %0d items, checked %0d results (%0d heap growths, %0d table-full drops)",
                 items_sent, result_count, grown_count, full_count);
        $display("settings covered first and best fit, headers 1 to 255, limits 0 to all ones");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
